>>> rtl/irtsd_pkg.sv
// ----------------------------------------------------------------------------
// IR tracking servo direction package
// Shared widths, register indexes and reset values of the direction decider.
// ----------------------------------------------------------------------------
`default_nettype none

package irtsd_pkg;

  // Default sizes of the sensor samples and streak counters.
  localparam int READING_BITS_DEF = 10;
  localparam int STREAK_BITS_DEF  = 16;

  // Widths of the configuration registers.
  localparam int THRESH_W = 10;
  localparam int HOLD_W   = 16;
  localparam int DUTY_W   = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PRESENCE_THRESHOLD = 3'd0;
  localparam cfg_idx_t REG_LEAD_MARGIN        = 3'd1;
  localparam cfg_idx_t REG_HOLD_COUNT         = 3'd2;
  localparam cfg_idx_t REG_LEFT_DUTY          = 3'd3;
  localparam cfg_idx_t REG_RIGHT_DUTY         = 3'd4;

  // Register values after reset.
  localparam logic [THRESH_W-1:0] PRESENCE_THRESHOLD_RST = 10'd600;
  localparam logic [THRESH_W-1:0] LEAD_MARGIN_RST        = 10'd50;
  localparam logic [HOLD_W-1:0]   HOLD_COUNT_RST         = 16'd200;
  localparam logic [DUTY_W-1:0]   LEFT_DUTY_RST          = 16'd1376;
  localparam logic [DUTY_W-1:0]   RIGHT_DUTY_RST         = 16'd1706;

endpackage

`default_nettype wire

>>> rtl/irtsd_if.sv
// ----------------------------------------------------------------------------
// IR tracking servo direction channels
// Valid/ready channels for sensor triples and for direction results.
// ----------------------------------------------------------------------------
`default_nettype none

interface irtsd_in_if
  import irtsd_pkg::*;
#(
  parameter int READING_BITS = READING_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [READING_BITS-1:0] left_reading;
  logic [READING_BITS-1:0] middle_reading;
  logic [READING_BITS-1:0] right_reading;

  modport source (
    output valid, left_reading, middle_reading, right_reading,
    input  ready
  );
  modport sink (
    input  valid, left_reading, middle_reading, right_reading,
    output ready
  );
endinterface

interface irtsd_out_if
  import irtsd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              turning_left;
  logic              turning_right;
  logic [DUTY_W-1:0] servo_duty;

  modport source (
    output valid, turning_left, turning_right, servo_duty,
    input  ready
  );
  modport sink (
    input  valid, turning_left, turning_right, servo_duty,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/ir_tracking_servo_direction_top.sv
// ----------------------------------------------------------------------------
// IR tracking servo direction decider
// Turns left/middle/right IR readings into direction flags and a servo duty.
// ----------------------------------------------------------------------------
// Usage: sensor triples enter on in_ch, one word per valid/ready handshake.
// Every accepted word yields exactly one result word on out_ch carrying the
// turning_left and turning_right flags and the servo compare value.
// The block is a two-stage pipeline: an input register holds the accepted
// triple, the decision logic works combinationally from it, and a result
// register holds the outcome. A result moves from the input register into
// the result register and is then offered on out_ch, and one triple can be
// taken every cycle while the receiver keeps out_ch.ready high.
// The streak counters and direction flags update as a triple moves from the
// input register into the result register, so each decision sees the state
// left by the previous triple.
// When the receiver holds out_ch.ready low, the result register keeps its
// word, the input register fills, and in_ch.ready drops until space frees.
// Reset (rst_n low, synchronous) empties both stages, clears the flags and
// streaks, and loads the register defaults: threshold 600, margin 50,
// hold count 200, left duty 1376, right duty 1706. The user writes registers
// via cfg_wr_en/cfg_index/cfg_data only while the block is idle; the block
// does not enforce it. Writes to indexes beyond the right duty are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_tracking_servo_direction_top
  import irtsd_pkg::*;
#(
  parameter int READING_BITS = READING_BITS_DEF,
  parameter int STREAK_BITS  = STREAK_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  irtsd_in_if.sink                   in_ch,
  irtsd_out_if.source                out_ch,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Common compare width for readings and threshold/margin, plus a carry bit.
  localparam int RD_W  = (READING_BITS > THRESH_W) ? READING_BITS : THRESH_W;
  localparam int SUM_W = RD_W + 1;
  // Common width for streak versus hold count.
  localparam int CNT_W = (STREAK_BITS > HOLD_W) ? STREAK_BITS : HOLD_W;

  // Configuration registers.
  logic [THRESH_W-1:0] presence_threshold_r;
  logic [THRESH_W-1:0] lead_margin_r;
  logic [HOLD_W-1:0]   hold_count_r;
  logic [DUTY_W-1:0]   left_duty_r;
  logic [DUTY_W-1:0]   right_duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presence_threshold_r <= PRESENCE_THRESHOLD_RST;
      lead_margin_r        <= LEAD_MARGIN_RST;
      hold_count_r         <= HOLD_COUNT_RST;
      left_duty_r          <= LEFT_DUTY_RST;
      right_duty_r         <= RIGHT_DUTY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PRESENCE_THRESHOLD: presence_threshold_r <= cfg_data[THRESH_W-1:0];
        REG_LEAD_MARGIN:        lead_margin_r        <= cfg_data[THRESH_W-1:0];
        REG_HOLD_COUNT:         hold_count_r         <= cfg_data[HOLD_W-1:0];
        REG_LEFT_DUTY:          left_duty_r          <= cfg_data[DUTY_W-1:0];
        REG_RIGHT_DUTY:         right_duty_r         <= cfg_data[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline handshake. The input stage moves on whenever the result
  // register is empty or is being emptied in this cycle.
  logic in_valid_r;
  logic out_valid_r;
  logic advance;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register.
  logic [RD_W-1:0] left_r;
  logic [RD_W-1:0] middle_r;
  logic [RD_W-1:0] right_r;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      left_r   <= RD_W'(in_ch.left_reading);
      middle_r <= RD_W'(in_ch.middle_reading);
      right_r  <= RD_W'(in_ch.right_reading);
    end
  end

  // Decision logic.
  logic                   left_active_r, left_active_nxt;
  logic                   right_active_r, right_active_nxt;
  logic [STREAK_BITS-1:0] left_streak_r, left_streak_nxt;
  logic [STREAK_BITS-1:0] right_streak_r, right_streak_nxt;

  logic                   left_big;
  logic                   middle_big;
  logic [RD_W-1:0]        big;
  logic                   present;
  logic [SUM_W-1:0]       lead_ext;
  logic                   left_lead;
  logic                   right_lead;
  logic [STREAK_BITS-1:0] left_bump;
  logic [STREAK_BITS-1:0] right_bump;
  logic [DUTY_W-1:0]      duty;

  always_comb begin
    left_big   = (left_r >= middle_r) && (left_r >= right_r);
    middle_big = !left_big && (middle_r >= right_r);
    if (left_big) begin
      big = left_r;
    end else if (middle_big) begin
      big = middle_r;
    end else begin
      big = right_r;
    end
    present  = big > RD_W'(presence_threshold_r);
    lead_ext = SUM_W'(lead_margin_r);

    left_lead  = ({1'b0, left_r} > ({1'b0, middle_r} + lead_ext)) &&
                 ({1'b0, left_r} > ({1'b0, right_r} + lead_ext));
    right_lead = ({1'b0, right_r} > ({1'b0, middle_r} + lead_ext)) &&
                 ({1'b0, right_r} > ({1'b0, left_r} + lead_ext));

    // Streaks saturate at all ones.
    left_bump  = (&left_streak_r) ? left_streak_r :
                 left_streak_r + STREAK_BITS'(1);
    right_bump = (&right_streak_r) ? right_streak_r :
                 right_streak_r + STREAK_BITS'(1);

    left_active_nxt  = left_active_r;
    right_active_nxt = right_active_r;
    left_streak_nxt  = left_streak_r;
    right_streak_nxt = right_streak_r;

    if (!present || middle_big) begin
      left_active_nxt  = 1'b0;
      right_active_nxt = 1'b0;
      left_streak_nxt  = '0;
      right_streak_nxt = '0;
    end else if (left_big) begin
      if (left_lead) begin
        left_streak_nxt = left_bump;
        if (right_active_r) begin
          // A lead for the opposite side stops motion instead of reversing.
          left_active_nxt  = 1'b0;
          right_active_nxt = 1'b0;
          right_streak_nxt = '0;
        end else if (CNT_W'(left_bump) >= CNT_W'(hold_count_r)) begin
          left_active_nxt  = 1'b1;
          right_active_nxt = 1'b0;
        end
      end
    end else begin
      if (right_lead) begin
        right_streak_nxt = right_bump;
        if (left_active_r) begin
          left_active_nxt  = 1'b0;
          right_active_nxt = 1'b0;
          left_streak_nxt  = '0;
        end else if (CNT_W'(right_bump) >= CNT_W'(hold_count_r)) begin
          left_active_nxt  = 1'b0;
          right_active_nxt = 1'b1;
        end
      end
    end

    if (left_active_nxt) begin
      duty = left_duty_r;
    end else if (right_active_nxt) begin
      duty = right_duty_r;
    end else begin
      duty = '0;
    end
  end

  // Direction state advances once per triple.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_active_r  <= 1'b0;
      right_active_r <= 1'b0;
      left_streak_r  <= '0;
      right_streak_r <= '0;
    end else if (advance) begin
      left_active_r  <= left_active_nxt;
      right_active_r <= right_active_nxt;
      left_streak_r  <= left_streak_nxt;
      right_streak_r <= right_streak_nxt;
    end
  end

  // Result register.
  logic              turning_left_r;
  logic              turning_right_r;
  logic [DUTY_W-1:0] servo_duty_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      turning_left_r  <= left_active_nxt;
      turning_right_r <= right_active_nxt;
      servo_duty_r    <= duty;
    end
  end

  assign out_ch.turning_left  = turning_left_r;
  assign out_ch.turning_right = turning_right_r;
  assign out_ch.servo_duty    = servo_duty_r;

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// IR tracking servo direction testbench
// Drives sensor triples into the direction decider over valid/ready, predicts
// the direction flags and servo duty of every triple in an in-bench tracker,
// and compares each result word against the oldest prediction. Directed
// cases come first, then randomized streak-building sequences under several
// register settings, with random idling on both channels and one long
// receiver stall.
// ----------------------------------------------------------------------------
module tb;
  import irtsd_pkg::*;

  localparam int READ_W         = READING_BITS_DEF;
  localparam int RUN_W          = STREAK_BITS_DEF;
  localparam int READING_MAX    = (1 << READ_W) - 1;
  localparam int MAX_GAP        = 6;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 4;

  typedef logic [READ_W-1:0] reading_t;

  // One result word as it leaves the block.
  typedef struct packed {
    logic              turning_left;
    logic              turning_right;
    logic [DUTY_W-1:0] servo_duty;
  } direction_t;

  // Shapes of sensor triples that the random stimulus draws from.
  typedef enum int {
    TRIPLE_LEFT_LEAD,
    TRIPLE_RIGHT_LEAD,
    TRIPLE_WEAK_LEAD,
    TRIPLE_MIDDLE_TOP,
    TRIPLE_FAINT,
    TRIPLE_NOISE
  } triple_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_wr_en;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  irtsd_in_if #(.READING_BITS(READ_W)) in_ch ();
  irtsd_out_if                         out_ch ();

  ir_tracking_servo_direction_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Tracker copy of the registers and of the decision state.
  logic [THRESH_W-1:0] presence_thr_q;
  logic [THRESH_W-1:0] margin_q;
  logic [HOLD_W-1:0]   hold_q;
  logic [DUTY_W-1:0]   left_duty_q;
  logic [DUTY_W-1:0]   right_duty_q;
  logic                left_on;
  logic                right_on;
  logic [RUN_W-1:0]    left_run;
  logic [RUN_W-1:0]    right_run;

  // Predicted result words, oldest first.
  direction_t pending_directions[$];

  int mismatch_count = 0;
  int stray_count    = 0;

  // When set, both channels run without idle cycles.
  bit steady_flow = 1'b0;
  // Asks the result side for one long stall on its next word.
  bit hold_off_request = 1'b0;

  function automatic void clear_tracking();
    left_on   = 1'b0;
    right_on  = 1'b0;
    left_run  = '0;
    right_run = '0;
  endfunction

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Advances the tracker by one triple and returns the word the block must send.
  function automatic direction_t predict_direction(reading_t l, reading_t m, reading_t r);
    int         lv;
    int         mv;
    int         rv;
    int         top;
    int         lead;
    direction_t res;
    lv   = l;
    mv   = m;
    rv   = r;
    lead = margin_q;
    if (lv >= mv && lv >= rv) top = lv;
    else if (mv >= rv) top = mv;
    else top = rv;

    if (top <= int'(presence_thr_q)) begin
      clear_tracking();
    end else if (lv >= mv && lv >= rv) begin
      if (lv > mv + lead && lv > rv + lead) begin
        if (left_run != '1) left_run = left_run + RUN_W'(1);
        if (right_on) begin
          // An opposite lead stops the head instead of reversing it.
          left_on   = 1'b0;
          right_on  = 1'b0;
          right_run = '0;
        end else if (left_run >= hold_q) begin
          left_on  = 1'b1;
          right_on = 1'b0;
        end
      end
    end else if (mv >= rv) begin
      clear_tracking();
    end else begin
      if (rv > mv + lead && rv > lv + lead) begin
        if (right_run != '1) right_run = right_run + RUN_W'(1);
        if (left_on) begin
          left_on  = 1'b0;
          right_on = 1'b0;
          left_run = '0;
        end else if (right_run >= hold_q) begin
          left_on  = 1'b0;
          right_on = 1'b1;
        end
      end
    end

    res.turning_left  = left_on;
    res.turning_right = right_on;
    res.servo_duty    = left_on ? left_duty_q : (right_on ? right_duty_q : '0);
    return res;
  endfunction

  // Builds a triple of the requested shape under the current register values.
  function automatic void make_triple(input triple_kind_t kind,
                                      output reading_t l, output reading_t m,
                                      output reading_t r);
    int thr;
    int lead;
    int lo;
    int top;
    int a;
    int b;
    thr  = presence_thr_q;
    lead = margin_q;
    top  = $urandom_range(0, READING_MAX);
    a    = $urandom_range(0, READING_MAX);
    b    = $urandom_range(0, READING_MAX);
    case (kind)
      TRIPLE_LEFT_LEAD, TRIPLE_RIGHT_LEAD: begin
        // The winner must clear the threshold and beat both others by the margin.
        lo = ((thr > lead) ? thr : lead) + 1;
        if (lo <= READING_MAX) begin
          top = $urandom_range(READING_MAX, lo);
          a   = $urandom_range(0, top - lead - 1);
          b   = $urandom_range(0, top - lead - 1);
        end
        if (kind == TRIPLE_LEFT_LEAD) begin
          l = reading_t'(top); m = reading_t'(a); r = reading_t'(b);
        end else begin
          r = reading_t'(top); l = reading_t'(a); m = reading_t'(b);
        end
      end
      TRIPLE_WEAK_LEAD: begin
        // Largest and present, but one other reading sits within the margin.
        if (thr < READING_MAX) begin
          top = $urandom_range(READING_MAX, thr + 1);
          a   = $urandom_range(top, (top > lead) ? top - lead : 0);
          b   = $urandom_range(0, top);
        end
        if ($urandom_range(0, 1) == 0) begin
          l = reading_t'(top); m = reading_t'(a); r = reading_t'(b);
        end else begin
          r = reading_t'(top); l = reading_t'(b); m = reading_t'(a);
        end
      end
      TRIPLE_MIDDLE_TOP: begin
        m = reading_t'(top);
        l = reading_t'($urandom_range(0, top));
        r = reading_t'($urandom_range(0, top));
      end
      TRIPLE_FAINT: begin
        l = reading_t'($urandom_range(0, thr));
        m = reading_t'($urandom_range(0, thr));
        r = reading_t'($urandom_range(0, thr));
      end
      default: begin
        l = reading_t'(top); m = reading_t'(a); r = reading_t'(b);
      end
    endcase
  endfunction

  // Offers one triple after a random gap and records its prediction once taken.
  task automatic send_triple(input reading_t l, input reading_t m, input reading_t r);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.left_reading   <= l;
    in_ch.middle_reading <= m;
    in_ch.right_reading  <= r;
    do @(posedge clk); while (!in_ch.ready);
    pending_directions.push_back(predict_direction(l, m, r));
  endtask

  // Withdraws the input and waits until every predicted word has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_directions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_PRESENCE_THRESHOLD: presence_thr_q = data[THRESH_W-1:0];
      REG_LEAD_MARGIN:        margin_q       = data[THRESH_W-1:0];
      REG_HOLD_COUNT:         hold_q         = data[HOLD_W-1:0];
      REG_LEFT_DUTY:          left_duty_q    = data[DUTY_W-1:0];
      REG_RIGHT_DUTY:         right_duty_q   = data[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Writes all five registers once the block is idle. The unused upper bits
  // of the 10-bit registers carry random junk that the block must drop.
  task automatic load_settings(input int thr, input int lead, input int hold,
                               input int ld, input int rd);
    logic [CFG_DATA_W-1:0] word;
    drain();
    word = CFG_DATA_W'($urandom);
    word[THRESH_W-1:0] = THRESH_W'(thr);
    write_register(REG_PRESENCE_THRESHOLD, word);
    word = CFG_DATA_W'($urandom);
    word[THRESH_W-1:0] = THRESH_W'(lead);
    write_register(REG_LEAD_MARGIN, word);
    write_register(REG_HOLD_COUNT, CFG_DATA_W'(hold));
    write_register(REG_LEFT_DUTY, CFG_DATA_W'(ld));
    write_register(REG_RIGHT_DUTY, CFG_DATA_W'(rd));
    end_writes();
  endtask

  // Streams bursts of one shape at a time. Runs of leads for one side last up
  // to three past the hold count (capped at eight), so flags can toggle.
  task automatic random_phase(input int count, input int thr, input int lead,
                              input int hold, input int ld, input int rd,
                              input bit steady);
    int           sent;
    int           pick;
    int           run;
    int           reach;
    triple_kind_t kind;
    reading_t     l;
    reading_t     m;
    reading_t     r;
    load_settings(thr, lead, hold, ld, rd);
    reach = (hold > 8) ? 8 : hold;
    sent  = 0;
    while (sent < count) begin
      steady_flow = steady || ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) kind = TRIPLE_LEFT_LEAD;
      else if (pick < 70) kind = TRIPLE_RIGHT_LEAD;
      else if (pick < 78) kind = TRIPLE_WEAK_LEAD;
      else if (pick < 85) kind = TRIPLE_MIDDLE_TOP;
      else if (pick < 92) kind = TRIPLE_FAINT;
      else kind = TRIPLE_NOISE;
      if (kind == TRIPLE_LEFT_LEAD || kind == TRIPLE_RIGHT_LEAD)
        run = $urandom_range(1, reach + 3);
      else
        run = $urandom_range(1, 3);
      repeat (run) begin
        if (sent < count) begin
          make_triple(kind, l, m, r);
          send_triple(l, m, r);
          sent++;
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // Register values straight out of reset: a lead below the hold count does
  // nothing visible, a lead inside the margin changes nothing, and readings
  // at the threshold count as absent.
  task automatic test_reset_defaults();
    send_triple(10'd601, 10'd0, 10'd0);
    send_triple(10'd700, 10'd650, 10'd0);
    send_triple(10'd600, 10'd600, 10'd600);
  endtask

  // Hold count of one so every decision shows up at once: activation, stop on
  // an opposite lead, tie-breaking toward left and then middle, middle on top.
  task automatic test_decisions();
    load_settings(600, 50, 1, LEFT_DUTY_RST, RIGHT_DUTY_RST);
    send_triple(10'd900, 10'd100, 10'd100);
    send_triple(10'd100, 10'd100, 10'd900);
    send_triple(10'd100, 10'd100, 10'd900);
    send_triple(10'd900, 10'd900, 10'd900);
    send_triple(10'd800, 10'd800, 10'd100);
    send_triple(10'd100, 10'd900, 10'd900);
    send_triple(10'd900, 10'd100, 10'd100);
    send_triple(10'd100, 10'd1000, 10'd200);
    send_triple(10'd100, 10'd100, 10'd900);
    send_triple(10'd1023, 10'd0, 10'd0);
    send_triple(10'd0, 10'd0, 10'd0);
  endtask

  // Register extremes, including a hold count of zero that activates on the
  // first qualifying triple and a margin too large to ever be met.
  task automatic test_register_extremes();
    load_settings(0, 0, 0, 0, 16'hFFFF);
    send_triple(10'd0, 10'd0, 10'd0);
    send_triple(10'd1, 10'd0, 10'd0);
    send_triple(10'd0, 10'd0, 10'd1);
    send_triple(10'd0, 10'd0, 10'd1);
    load_settings(READING_MAX, READING_MAX, 16'hFFFF, 16'hFFFF, 0);
    send_triple(10'd1023, 10'd1023, 10'd1023);
    send_triple(10'd1023, 10'd0, 10'd0);
    load_settings(0, READING_MAX, 1, 16'hFFFF, 16'hFFFF);
    send_triple(10'd1023, 10'd0, 10'd0);
    send_triple(10'd0, 10'd0, 10'd1023);
  endtask

  // Writes to indexes past the right duty must leave every register alone.
  task automatic test_spare_indexes();
    int idx;
    load_settings(100, 10, 1, 16'h1234, 16'h4321);
    for (idx = int'(REG_RIGHT_DUTY) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_register(cfg_idx_t'(idx), CFG_DATA_W'($urandom));
    end_writes();
    send_triple(10'd500, 10'd0, 10'd0);
    send_triple(10'd0, 10'd0, 10'd500);
    send_triple(10'd0, 10'd0, 10'd500);
  endtask

  // The result side stalls for a long stretch while triples keep coming, so
  // both pipeline stages fill and the input side has to stall.
  task automatic test_backpressure();
    reading_t l;
    reading_t m;
    reading_t r;
    load_settings(300, 20, 2, $urandom_range(0, 65535), $urandom_range(0, 65535));
    hold_off_request = 1'b1;
    steady_flow      = 1'b1;
    repeat (40) begin
      make_triple(($urandom_range(0, 1) == 0) ? TRIPLE_LEFT_LEAD : TRIPLE_RIGHT_LEAD, l, m, r);
      send_triple(l, m, r);
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_sequences();
    repeat (4)
      random_phase(240, $urandom_range(100, 800), $urandom_range(0, 150),
                   $urandom_range(1, 6), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), 1'b0);
    random_phase(200, 0, 0, 1, 0, 16'hFFFF, 1'b1);
    random_phase(120, READING_MAX, READING_MAX, 16'hFFFF, 16'hFFFF, 0, 1'b0);
    random_phase(200, $urandom_range(0, READING_MAX), $urandom_range(0, READING_MAX),
                 $urandom_range(0, 8), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), 1'b1);
    random_phase(300, $urandom_range(0, 700), $urandom_range(0, 300),
                 $urandom_range(1, 4), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), 1'b0);
  endtask

  // Compares one received word with the oldest prediction.
  task automatic check_direction(input direction_t seen);
    direction_t want;
    if (pending_directions.size() == 0) begin
      stray_count++;
      if (mismatch_count + stray_count <= MAX_REPORTS)
        $display("unexpected word: left=%0b right=%0b duty=%0d",
                 seen.turning_left, seen.turning_right, seen.servo_duty);
    end else begin
      want = pending_directions.pop_front();
      if (seen.turning_left !== want.turning_left ||
          seen.turning_right !== want.turning_right ||
          seen.servo_duty !== want.servo_duty) begin
        mismatch_count++;
        if (mismatch_count + stray_count <= MAX_REPORTS)
          $display({"word mismatch: expected left=%0b right=%0b duty=%0d, ",
                    "got left=%0b right=%0b duty=%0d"},
                   want.turning_left, want.turning_right, want.servo_duty,
                   seen.turning_left, seen.turning_right, seen.servo_duty);
      end
    end
  endtask

  // Result side: draws a stall before each word, honors a long hold-off
  // request, and checks every word it accepts.
  initial begin
    int         stall;
    direction_t seen;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall            = LONG_HOLD;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      seen.turning_left  = out_ch.turning_left;
      seen.turning_right = out_ch.turning_right;
      seen.servo_duty    = out_ch.servo_duty;
      check_direction(seen);
    end
  end

  // Watchdog: ends the run once neither channel has moved a word for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("ir_tracking_servo_direction_top verification failed");
    $finish;
  end

  // Main sequence: reset once, then each test in turn, then a final drain.
  initial begin
    in_ch.valid          = 1'b0;
    in_ch.left_reading   = '0;
    in_ch.middle_reading = '0;
    in_ch.right_reading  = '0;
    cfg_wr_en            = 1'b0;
    cfg_index            = REG_PRESENCE_THRESHOLD;
    cfg_data             = '0;
    presence_thr_q       = PRESENCE_THRESHOLD_RST;
    margin_q             = LEAD_MARGIN_RST;
    hold_q               = HOLD_COUNT_RST;
    left_duty_q          = LEFT_DUTY_RST;
    right_duty_q         = RIGHT_DUTY_RST;
    clear_tracking();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_decisions();
    test_register_extremes();
    test_spare_indexes();
    test_backpressure();
    test_random_sequences();
    drain();

    if (mismatch_count == 0 && stray_count == 0 && pending_directions.size() == 0)
      $display("ir_tracking_servo_direction_top verification clean");
    else
      $display("ir_tracking_servo_direction_top verification failed");
    $finish;
  end

endmodule
